// File: src/cft_pkg.sv
// Shared types and constants for the CSV field tokenizer.
// No dependencies; used by every module of the block through scoped names.
package cft_pkg;

   // Result kinds carried on the result channel's tuser.
   localparam logic [1:0] KIND_CONTENT = 2'd0;
   localparam logic [1:0] KIND_FIELD   = 2'd1;
   localparam logic [1:0] KIND_ROW     = 2'd2;

   // Fixed characters.
   localparam logic [7:0] CH_SP  = 8'h20;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_CR  = 8'h0D;

   // Register reset values.
   localparam logic [7:0] DELIM_RESET = 8'd44;
   localparam logic [7:0] QUOTE_RESET = 8'd34;

   // Register indexes on the csr channel.
   localparam logic CSR_DELIMITER  = 1'b0;
   localparam logic CSR_QUOTE_BYTE = 1'b1;

   // Byte class flags from the compare unit.
   typedef struct packed {
      logic ws;
      logic tab;
      logic cr;
      logic lf;
      logic quote;
      logic delim;
   } cls_type;

   // Commands to the held whitespace buffer.
   typedef struct packed {
      logic push;        // append one whitespace byte
      logic push_tab;    // 1 tab, 0 space
      logic clear_count; // forget held bytes after a flush
      logic clear_all;   // end of field: count and overflow flag
      logic rd_en;       // registered read of one entry
   } hbuf_cmd_type;

endpackage

// File: src/cft_classify.sv
// Byte compare unit: classifies one text byte against fixed characters
// and the delimiter and quote registers. Depends on cft_pkg.
module cft_classify (
   input  logic [7:0]      text_byte,
   input  logic [7:0]      delimiter,
   input  logic [7:0]      quote_byte,
   output cft_pkg::cls_type cls
);

   // One compare per class, shared by all parser modes
   always_comb begin
      cls.tab   = (text_byte == cft_pkg::CH_TAB);
      cls.ws    = (text_byte == cft_pkg::CH_SP) || (text_byte == cft_pkg::CH_TAB);
      cls.cr    = (text_byte == cft_pkg::CH_CR);
      cls.lf    = (text_byte == cft_pkg::CH_LF);
      cls.quote = (text_byte == quote_byte);
      cls.delim = (text_byte == delimiter);
   end

endmodule

// File: src/cft_held_buf.sv
// Held trailing whitespace buffer: one bit per entry (tab or space),
// fill count, overflow flag and a registered read port. Depends on cft_pkg.
module cft_held_buf #(
   parameter int DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  cft_pkg::hbuf_cmd_type                  cmd,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_idx,
   output logic                                   rd_tab,
   output logic [$clog2(DEPTH+1)-1:0]             count,
   output logic                                   overflow
);

   localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   logic            mem [DEPTH];
   logic            rd_tab_ff;
   logic [CntW-1:0] count_ff, count_in;
   logic            overflow_ff, overflow_in;
   logic            room;

   assign room = (count_ff < CntW'(DEPTH));

   // Entry storage and registered read
   always_ff @(posedge clock) begin
      if (cmd.push && room) begin
         mem[count_ff[IdxW-1:0]] <= cmd.push_tab;
      end
      if (cmd.rd_en) begin
         rd_tab_ff <= mem[rd_idx];
      end
   end

   // Fill count and overflow flag
   always_comb begin
      count_in    = count_ff;
      overflow_in = overflow_ff;
      if (cmd.clear_all) begin
         count_in    = '0;
         overflow_in = 1'b0;
      end else if (cmd.clear_count) begin
         count_in = '0;
      end else if (cmd.push) begin
         if (room) begin
            count_in = count_ff + CntW'(1);
         end else begin
            overflow_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
      end
   end

   assign rd_tab   = rd_tab_ff;
   assign count    = count_ff;
   assign overflow = overflow_ff;

endmodule

// File: src/csv_field_tokenizer_top.sv
// Top level of the CSV field tokenizer: parser sequencer, csr registers,
// result register. Depends on cft_pkg, cft_classify and cft_held_buf.
//
// Usage: text bytes arrive on the req_ channel, one per transfer, with
// req_tlast set on a final end-of-text transfer (its data is ignored).
// Each field leaves on the rsp_ channel as content bytes (tuser 0) and
// then an end-of-field (1) or end-of-row (2) mark; rsp_tlast flags the
// last result caused by one input transfer. Many inputs cause no result.
// The delimiter and quote byte are written on the csr_ channel while idle.
// Timing: a byte is accepted, evaluated in the next cycle and its result
// loaded into the result register in the content or mark state once that
// register is free; the next byte is accepted only back in idle. A content
// byte that follows held trailing whitespace first replays the held entries,
// each via read request and read-out states, through the registered read port.
// Reset (synchronous, active high) restores the default delimiter and
// quote, empties the buffer and starts at the beginning of a field.
// When the receiver stalls, the result register holds its transfer and
// the sequencer waits; no result is dropped.
module csv_field_tokenizer_top #(
   parameter int HELD_WS_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   // Input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic        req_tlast,   // end_of_text
   // Result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] content_byte, [8] ws_dropped, rest zero
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast,   // last
   // Configuration channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [7:0]  csr_data
);

   localparam int IdxW = (HELD_WS_DEPTH > 1) ? $clog2(HELD_WS_DEPTH) : 1;
   localparam int CntW = $clog2(HELD_WS_DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_EVAL, S_RDREQ, S_RDOUT, S_CONTENT, S_MARK
   } state_type;

   typedef enum logic [2:0] {
      M_START, M_PLAIN, M_QUOTED, M_QSEEN, M_AFTERQ
   } mode_type;

   typedef enum logic [1:0] {
      K_NONE, K_LF, K_CR
   } skip_type;

   // Configuration registers
   logic [7:0] delim_ff, quote_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff <= cft_pkg::DELIM_RESET;
         quote_ff <= cft_pkg::QUOTE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            cft_pkg::CSR_DELIMITER:  delim_ff <= csr_data;
            cft_pkg::CSR_QUOTE_BYTE: quote_ff <= csr_data;
            default:                 delim_ff <= delim_ff;
         endcase
      end
   end

   // Sequencer registers
   state_type       state_ff, state_in;
   mode_type        mode_ff, mode_in;
   skip_type        skip_ff, skip_in;
   logic            row_open_ff, row_open_in;
   logic [7:0]      byte_ff, byte_in;
   logic            eot_ff, eot_in;
   logic [1:0]      mark_ff, mark_in;
   logic [CntW-1:0] flush_idx_ff, flush_idx_in;

   // Result register
   logic            rsp_valid_ff, rsp_valid_in;
   logic [1:0]      rsp_kind_ff, rsp_kind_in;
   logic [7:0]      rsp_byte_ff, rsp_byte_in;
   logic            rsp_ws_ff, rsp_ws_in;
   logic            rsp_last_ff, rsp_last_in;

   cft_pkg::cls_type      cls;
   cft_pkg::hbuf_cmd_type hcmd;
   logic                  hb_tab;
   logic [CntW-1:0]       hb_count;
   logic                  hb_overflow;
   logic                  out_free;
   logic                  skip_hit;
   logic [CntW-1:0]       flush_next;

   cft_classify u_classify (
      .text_byte  (byte_ff),
      .delimiter  (delim_ff),
      .quote_byte (quote_ff),
      .cls        (cls)
   );

   cft_held_buf #(
      .DEPTH (HELD_WS_DEPTH)
   ) u_held_buf (
      .clock    (clock),
      .reset    (reset),
      .cmd      (hcmd),
      .rd_idx   (flush_idx_ff[IdxW-1:0]),
      .rd_tab   (hb_tab),
      .count    (hb_count),
      .overflow (hb_overflow)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign skip_hit   = ((skip_ff == K_LF) && cls.lf) || ((skip_ff == K_CR) && cls.cr);
   assign flush_next = flush_idx_ff + CntW'(1);

   // Parser step and result sequencing
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      skip_in      = skip_ff;
      row_open_in  = row_open_ff;
      byte_in      = byte_ff;
      eot_in       = eot_ff;
      mark_in      = mark_ff;
      flush_idx_in = flush_idx_ff;
      hcmd         = '0;
      hcmd.push_tab = cls.tab;

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_ws_in    = rsp_ws_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               byte_in  = req_tdata;
               eot_in   = req_tlast;
               state_in = S_EVAL;
            end
         end

         S_EVAL: begin
            state_in = S_IDLE;
            if (eot_ff) begin
               // close any open row and restart
               if (mode_ff != M_START || row_open_ff) begin
                  mark_in  = cft_pkg::KIND_ROW;
                  state_in = S_MARK;
               end else begin
                  hcmd.clear_all = 1'b1;
               end
               mode_in     = M_START;
               skip_in     = K_NONE;
               row_open_in = 1'b0;
            end else begin
               skip_in = K_NONE;
               if (!skip_hit) begin
                  case (mode_ff)
                     M_START: begin
                        if (cls.ws) begin
                           row_open_in = 1'b1;
                        end else if (cls.cr || cls.lf) begin
                           row_open_in = 1'b0;
                           skip_in     = cls.cr ? K_LF : K_CR;
                           mark_in     = cft_pkg::KIND_ROW;
                           state_in    = S_MARK;
                        end else if (cls.quote) begin
                           mode_in     = M_QUOTED;
                           row_open_in = 1'b1;
                        end else if (cls.delim) begin
                           row_open_in = 1'b1;
                           mark_in     = cft_pkg::KIND_FIELD;
                           state_in    = S_MARK;
                        end else begin
                           mode_in     = M_PLAIN;
                           row_open_in = 1'b1;
                           state_in    = S_CONTENT;
                        end
                     end

                     M_PLAIN: begin
                        if (cls.delim) begin
                           mode_in     = M_START;
                           row_open_in = 1'b1;
                           mark_in     = cft_pkg::KIND_FIELD;
                           state_in    = S_MARK;
                        end else if (cls.cr || cls.lf) begin
                           mode_in     = M_START;
                           row_open_in = 1'b0;
                           skip_in     = cls.cr ? K_LF : K_CR;
                           mark_in     = cft_pkg::KIND_ROW;
                           state_in    = S_MARK;
                        end else if (cls.ws) begin
                           hcmd.push = 1'b1;
                        end else if (hb_count != '0) begin
                           flush_idx_in = '0;
                           state_in     = S_RDREQ;
                        end else begin
                           state_in = S_CONTENT;
                        end
                     end

                     M_QUOTED: begin
                        if (cls.quote) begin
                           mode_in = M_QSEEN;
                        end else begin
                           state_in = S_CONTENT;
                        end
                     end

                     default: begin
                        // quote seen inside a quoted field, or after closing quote
                        if (mode_ff == M_QSEEN && cls.quote) begin
                           mode_in  = M_QUOTED;
                           state_in = S_CONTENT;
                        end else if (cls.ws) begin
                           mode_in = M_AFTERQ;
                        end else if (cls.delim) begin
                           mode_in     = M_START;
                           row_open_in = 1'b1;
                           mark_in     = cft_pkg::KIND_FIELD;
                           state_in    = S_MARK;
                        end else begin
                           // stray byte ends the row like LF and is dropped
                           mode_in     = M_START;
                           row_open_in = 1'b0;
                           skip_in     = cls.cr ? K_LF : K_CR;
                           mark_in     = cft_pkg::KIND_ROW;
                           state_in    = S_MARK;
                        end
                     end
                  endcase
               end
            end
         end

         S_RDREQ: begin
            hcmd.rd_en = 1'b1;
            state_in   = S_RDOUT;
         end

         S_RDOUT: begin
            // replay one held whitespace byte
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = cft_pkg::KIND_CONTENT;
               rsp_byte_in  = hb_tab ? cft_pkg::CH_TAB : cft_pkg::CH_SP;
               rsp_ws_in    = hb_overflow;
               rsp_last_in  = 1'b0;
               flush_idx_in = flush_next;
               if (flush_next == hb_count) begin
                  hcmd.clear_count = 1'b1;
                  state_in         = S_CONTENT;
               end else begin
                  state_in = S_RDREQ;
               end
            end
         end

         S_CONTENT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = cft_pkg::KIND_CONTENT;
               rsp_byte_in  = byte_ff;
               rsp_ws_in    = hb_overflow;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end

         S_MARK: begin
            // end of field: the mark carries the overflow flag, then clear
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_kind_in    = mark_ff;
               rsp_byte_in    = '0;
               rsp_ws_in      = hb_overflow;
               rsp_last_in    = 1'b1;
               hcmd.clear_all = 1'b1;
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= M_START;
         skip_ff      <= K_NONE;
         row_open_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         skip_ff      <= skip_in;
         row_open_ff  <= row_open_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      byte_ff      <= byte_in;
      eot_ff       <= eot_in;
      mark_ff      <= mark_in;
      flush_idx_ff <= flush_idx_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_ws_ff    <= rsp_ws_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ws_ff, rsp_byte_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
